### rtl/assert_macros.svh
// assertion macros used by text_number_to_byte_parser.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// consequent must follow the antecedent (use |-> or |=> inside prop)
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

### rtl/tnbp_pkg.sv
// types, character codes and helpers for the text to byte parser
`default_nettype none

package tnbp_pkg;

  // line level mode, one-hot
  typedef enum logic [7:0] {
    LmStart  = 8'b0000_0001,
    LmHyphen = 8'b0000_0010,
    LmEchoSp = 8'b0000_0100,
    LmEcho   = 8'b0000_1000,
    LmHex    = 8'b0001_0000,
    LmDec    = 8'b0010_0000,
    LmIgnore = 8'b0100_0000,
    LmCut    = 8'b1000_0000
  } line_mode_e;

  // token level phase, one-hot
  typedef enum logic [6:0] {
    PhIdle   = 7'b000_0001,
    PhBlank  = 7'b000_0010,
    PhSign   = 7'b000_0100,
    PhZero   = 7'b000_1000,
    PhDigits = 7'b001_0000,
    PhJunk   = 7'b010_0000,
    PhSilent = 7'b100_0000
  } phase_e;

  localparam logic [7:0] ChNul    = 8'd0;
  localparam logic [7:0] ChTab    = 8'd9;
  localparam logic [7:0] ChNl     = 8'd10;
  localparam logic [7:0] ChVt     = 8'd11;
  localparam logic [7:0] ChFf     = 8'd12;
  localparam logic [7:0] ChCr     = 8'd13;
  localparam logic [7:0] ChSp     = 8'd32;
  localparam logic [7:0] ChPlus   = 8'd43;
  localparam logic [7:0] ChHyphen = 8'd45;
  localparam logic [7:0] ChSlash  = 8'd47;
  localparam logic [7:0] ChStar   = 8'd42;
  localparam logic [7:0] ChLowC   = 8'd99;
  localparam logic [7:0] ChLowD   = 8'd100;
  localparam logic [7:0] ChLowX   = 8'd120;
  localparam logic [7:0] ChUpX    = 8'd88;

  // parser state kept between items
  typedef struct packed {
    line_mode_e  line_mode;
    phase_e      phase;
    logic [7:0]  acc;
    logic [7:0]  last_val;
    logic        neg;
    logic        seen;
    logic        in_comment;
    logic [7:0]  first_char;
  } state_t;

  // results of one item: count 0..2, second byte is always the last one
  typedef struct packed {
    logic [1:0]  cnt;
    logic [7:0]  b0;
    logic [7:0]  b1;
  } step_res_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  val;
  } digit_t;

  // digit decode, hex letters only when hex is set
  function automatic digit_t digit_val(input logic [7:0] c, input logic hex);
    digit_t d;
    d = '0;
    if (c inside {[8'd48:8'd57]}) begin
      d.ok  = 1'b1;
      d.val = 4'(c - 8'd48);
    end else if (hex && (c inside {[8'd97:8'd102]})) begin
      d.ok  = 1'b1;
      d.val = 4'(c - 8'd87);
    end else if (hex && (c inside {[8'd65:8'd70]})) begin
      d.ok  = 1'b1;
      d.val = 4'(c - 8'd55);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/tnbp_step.sv
// next state and result bytes for one character
`default_nettype none

module tnbp_step (
  input  wire logic [7:0]       char_i,
  input  wire tnbp_pkg::state_t st_i,
  output tnbp_pkg::state_t      st_o,
  output tnbp_pkg::step_res_t   res_o
);

  logic            hex_mode;
  tnbp_pkg::digit_t dig;
  logic            te_emit;
  logic [7:0]      te_val;
  logic            is_ws;

  // token end: clear token fields, latch value when digits were seen in an active token outside a comment
  function automatic tnbp_pkg::state_t tok_clear(input tnbp_pkg::state_t s,
                                                 input logic [7:0] v);
    tnbp_pkg::state_t r;
    r = s;
    if (s.seen && s.phase != tnbp_pkg::PhIdle && s.phase != tnbp_pkg::PhSilent &&
        !s.in_comment) begin
      r.last_val = v;
    end
    r.phase      = tnbp_pkg::PhIdle;
    r.first_char = '0;
    r.neg        = 1'b0;
    r.seen       = 1'b0;
    r.acc        = '0;
    return r;
  endfunction

  // start of a new line
  function automatic tnbp_pkg::state_t line_clear(input tnbp_pkg::state_t s);
    tnbp_pkg::state_t r;
    r = s;
    r.line_mode  = tnbp_pkg::LmStart;
    r.in_comment = 1'b0;
    r.phase      = tnbp_pkg::PhIdle;
    r.first_char = '0;
    return r;
  endfunction

  // line start leaves hex mode unless skipped
  assign hex_mode = (st_i.line_mode == tnbp_pkg::LmHex) ||
                    (st_i.line_mode == tnbp_pkg::LmStart);
  assign dig      = tnbp_pkg::digit_val(char_i, hex_mode);
  assign is_ws    = (char_i == tnbp_pkg::ChTab) || (char_i == tnbp_pkg::ChVt) ||
                    (char_i == tnbp_pkg::ChFf) || (char_i == tnbp_pkg::ChCr);

  // value a finished token puts out
  assign te_emit = (st_i.phase != tnbp_pkg::PhIdle) && (st_i.phase != tnbp_pkg::PhSilent) &&
                   !st_i.in_comment;
  assign te_val  = st_i.seen ? (st_i.neg ? 8'(8'd0 - st_i.acc) : st_i.acc) : st_i.last_val;

  always_comb begin
    tnbp_pkg::line_mode_e lm;
    tnbp_pkg::phase_e     ph;
    logic                 skip;
    logic                 done;
    st_o  = st_i;
    res_o = '0;
    lm    = st_i.line_mode;
    ph    = st_i.phase;
    skip  = 1'b0;
    done  = 1'b0;

    // leading spaces and the hyphen at line start
    if (lm == tnbp_pkg::LmStart) begin
      if (char_i == tnbp_pkg::ChSp) begin
        skip = 1'b1;
      end else if (char_i == tnbp_pkg::ChHyphen) begin
        st_o.line_mode = tnbp_pkg::LmHyphen;
        skip = 1'b1;
      end else begin
        lm = tnbp_pkg::LmHex;
        st_o.line_mode = tnbp_pkg::LmHex;
      end
    end

    if (!skip) begin
      case (lm)
        tnbp_pkg::LmHyphen: begin
          if (char_i == tnbp_pkg::ChNl)        st_o = line_clear(st_i);
          else if (char_i == tnbp_pkg::ChLowC) st_o.line_mode = tnbp_pkg::LmEchoSp;
          else if (char_i == tnbp_pkg::ChLowD) st_o.line_mode = tnbp_pkg::LmDec;
          else                                 st_o.line_mode = tnbp_pkg::LmIgnore;
        end
        tnbp_pkg::LmEchoSp, tnbp_pkg::LmEcho: begin
          if (!(lm == tnbp_pkg::LmEchoSp && char_i == tnbp_pkg::ChSp)) begin
            st_o.line_mode = tnbp_pkg::LmEcho;
            if (char_i == tnbp_pkg::ChNul) begin
              st_o.line_mode = tnbp_pkg::LmIgnore;
            end else begin
              res_o.cnt = 2'd1;
              res_o.b0  = char_i;
              if (char_i == tnbp_pkg::ChNl) st_o = line_clear(st_i);
            end
          end
        end
        tnbp_pkg::LmHex, tnbp_pkg::LmDec: begin
          if (char_i == tnbp_pkg::ChSp) begin
            st_o = tok_clear(st_o, te_val);
            if (te_emit) begin
              res_o.cnt = 2'd1;
              res_o.b0  = te_val;
            end
          end else if (char_i == tnbp_pkg::ChNl) begin
            st_o = line_clear(tok_clear(st_o, te_val));
            if (te_emit) begin
              res_o.cnt = 2'd2;
              res_o.b0  = te_val;
              res_o.b1  = tnbp_pkg::ChNl;
            end else begin
              res_o.cnt = 2'd1;
              res_o.b0  = tnbp_pkg::ChNl;
            end
          end else if (char_i == tnbp_pkg::ChNul) begin
            st_o = tok_clear(st_o, te_val);
            st_o.line_mode = tnbp_pkg::LmCut;
            if (te_emit) begin
              res_o.cnt = 2'd1;
              res_o.b0  = te_val;
            end
          end else begin
            // one character of a token
            ph = st_i.phase;
            if (ph == tnbp_pkg::PhIdle) begin
              st_o.first_char = char_i;
              st_o.acc        = '0;
              st_o.neg        = 1'b0;
              st_o.seen       = 1'b0;
              st_o.phase      = tnbp_pkg::PhBlank;
              ph              = tnbp_pkg::PhBlank;
            end else if (st_i.first_char != tnbp_pkg::ChNul) begin
              st_o.first_char = '0;
              if (!st_i.in_comment && st_i.first_char == tnbp_pkg::ChSlash &&
                  char_i == tnbp_pkg::ChStar) begin
                st_o.in_comment = 1'b1;
                st_o.phase      = tnbp_pkg::PhSilent;
                done            = 1'b1;
              end else if (st_i.in_comment && st_i.first_char == tnbp_pkg::ChStar &&
                           char_i == tnbp_pkg::ChSlash) begin
                st_o.in_comment = 1'b0;
                st_o.phase      = tnbp_pkg::PhSilent;
                done            = 1'b1;
              end
            end
            if (!done && !st_i.in_comment && ph != tnbp_pkg::PhSilent) begin
              case (ph)
                tnbp_pkg::PhBlank, tnbp_pkg::PhSign: begin
                  if (ph == tnbp_pkg::PhBlank && is_ws) begin
                    st_o.phase = ph;
                  end else if (ph == tnbp_pkg::PhBlank &&
                               (char_i == tnbp_pkg::ChPlus || char_i == tnbp_pkg::ChHyphen)) begin
                    st_o.neg   = (char_i == tnbp_pkg::ChHyphen);
                    st_o.phase = tnbp_pkg::PhSign;
                  end else if (!dig.ok) begin
                    st_o.phase = tnbp_pkg::PhJunk;
                  end else begin
                    st_o.seen  = 1'b1;
                    st_o.acc   = {4'd0, dig.val};
                    st_o.phase = (hex_mode && dig.val == 4'd0) ? tnbp_pkg::PhZero
                                                               : tnbp_pkg::PhDigits;
                  end
                end
                tnbp_pkg::PhZero: begin
                  if (char_i == tnbp_pkg::ChLowX || char_i == tnbp_pkg::ChUpX) begin
                    st_o.phase = tnbp_pkg::PhDigits;
                  end else if (!dig.ok) begin
                    st_o.phase = tnbp_pkg::PhJunk;
                  end else begin
                    st_o.acc   = {4'd0, dig.val};
                    st_o.phase = tnbp_pkg::PhDigits;
                  end
                end
                tnbp_pkg::PhDigits: begin
                  if (!dig.ok) begin
                    st_o.phase = tnbp_pkg::PhJunk;
                  end else if (hex_mode) begin
                    st_o.acc = {st_i.acc[3:0], dig.val};
                  end else begin
                    st_o.acc = 8'({1'b0, st_i.acc, 3'd0} + {3'd0, st_i.acc, 1'b0} +
                                  {8'd0, dig.val});
                  end
                end
                default: begin
                  st_o.phase = ph;
                end
              endcase
            end
          end
        end
        tnbp_pkg::LmCut: begin
          if (char_i == tnbp_pkg::ChNl) begin
            res_o.cnt = 2'd1;
            res_o.b0  = tnbp_pkg::ChNl;
            st_o      = line_clear(st_i);
          end
        end
        default: begin
          if (char_i == tnbp_pkg::ChNl) st_o = line_clear(st_i);
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/text_number_to_byte_parser.sv
// result bytes are written into the output queue as their character is taken
// one character per cycle while input ready is high; a character may give two
// results, absorbed by a four entry output queue
// input ready drops while the queue holds more than two bytes
// reset clears parser state and the queue, the last value starts at zero
`default_nettype none
`include "assert_macros.svh"

module text_number_to_byte_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_char
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast    // last
);

  localparam int unsigned QDepth = 4;

  tnbp_pkg::state_t    st_q, st_d;
  tnbp_pkg::step_res_t res;
  logic                accept, pop;
  logic [1:0]          wr_ptr_q, rd_ptr_q;
  logic [2:0]          count_q;
  logic [8:0]          q_mem [QDepth];

  // per character parser logic
  tnbp_step u_step (
    .char_i (s_axis_tdata),
    .st_i   (st_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  assign s_axis_tready = (count_q <= 3'd2);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{line_mode: tnbp_pkg::LmStart, phase: tnbp_pkg::PhIdle, default: '0};
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  // output queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (accept) wr_ptr_q <= wr_ptr_q + res.cnt;
      if (pop)    rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_q + (accept ? {1'b0, res.cnt} : 3'd0) - {2'd0, pop};
    end
  end

  // output queue storage, byte plus last flag
  always_ff @(posedge clk_i) begin
    if (accept && res.cnt != 2'd0) begin
      q_mem[wr_ptr_q] <= {res.cnt == 2'd1, res.b0};
    end
    if (accept && res.cnt == 2'd2) begin
      q_mem[wr_ptr_q + 2'd1] <= {1'b1, res.b1};
    end
  end

  assign m_axis_tvalid = (count_q != 3'd0);
  assign m_axis_tdata  = q_mem[rd_ptr_q][7:0];
  assign m_axis_tlast  = q_mem[rd_ptr_q][8];

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= 3'd4)
  `ASSERT_PROP(a_two_push, clk_i, rst_ni,
    (accept && res.cnt == 2'd2 && !pop) |=> (count_q == $past(count_q) + 3'd2))
  `ASSERT_PROP(a_comment_mode, clk_i, rst_ni,
    st_q.in_comment |-> (st_q.line_mode == tnbp_pkg::LmHex ||
      st_q.line_mode == tnbp_pkg::LmDec || st_q.line_mode == tnbp_pkg::LmCut))

endmodule

`default_nettype wire
